>>> rtl/core/indexed_list_insert_delete_unit_assert.svh
// Assertion macros used by the checker file of the list unit.
`ifndef INDEXED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_UNIT_ASSERT_SVH

// Property that holds at every clock edge outside reset.
`define ILID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define ILID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ilid_pkg.sv
`timescale 1ns / 1ps

package ilid_pkg;

  localparam int unsigned CAPACITY = 64;

  localparam int unsigned IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

  // Removed-value collection: cells are ORed in groups, groups in a second stage.
  localparam int unsigned GRP  = 8;
  localparam int unsigned NGRP = (CAPACITY + GRP - 1) / GRP;

  localparam logic [DATA_W-1:0] WORD_ERR  = '1;
  localparam logic [DATA_W-1:0] WORD_ZERO = '0;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND    = 3'd0,
    ACT_REM_LAST  = 3'd1,
    ACT_INS_FRONT = 3'd2,
    ACT_INS_AT    = 3'd3,
    ACT_REM_AT    = 3'd4,
    ACT_REM_FIRST = 3'd5
  } action_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_ERR  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] data;
  } cmd_t;

  // Result fields known at accept time.
  typedef struct packed {
    logic              use_sel;
    logic [DATA_W-1:0] data;
    status_e           status;
    logic [LEN_W-1:0]  length;
  } res_t;

endpackage

>>> rtl/core/ilid_in_if.sv
`timescale 1ns / 1ps

interface ilid_in_if;
  import ilid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] data_in;

  modport source (output valid, output action, output position, output data_in, input ready);
  modport sink (input valid, input action, input position, input data_in, output ready);
endinterface

>>> rtl/core/ilid_out_if.sv
`timescale 1ns / 1ps

interface ilid_out_if;
  import ilid_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] data_out;
  logic [ST_W-1:0]          status;
  logic [LEN_W-1:0]         length;

  modport source (output valid, output data_out, output status, output length, input ready);
  modport sink (input valid, input data_out, input status, input length, output ready);
endinterface

>>> rtl/core/ilid_cell.sv
`timescale 1ns / 1ps

module ilid_cell (
  input  logic                         clk_i,
  input  logic [ilid_pkg::IDX_W-1:0]   idx_i,
  input  ilid_pkg::cmd_t               cmd_i,
  input  logic [ilid_pkg::DATA_W-1:0]  left_i,
  input  logic [ilid_pkg::DATA_W-1:0]  right_i,
  output logic [ilid_pkg::DATA_W-1:0]  val_o,
  output logic [ilid_pkg::DATA_W-1:0]  tap_o
);
  import ilid_pkg::*;

  logic [DATA_W-1:0] val_d, val_q;

  always_comb begin
    val_d = val_q;
    priority if (cmd_i.ins && (idx_i > cmd_i.pos)) begin
      val_d = left_i;
    end else if (cmd_i.ins && (idx_i == cmd_i.pos)) begin
      val_d = cmd_i.data;
    end else if (cmd_i.rem && (idx_i >= cmd_i.pos)) begin
      val_d = right_i;
    end else begin
      val_d = val_q;
    end
  end

  // Payload only: no reset.
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;
  // Offer the current value when this slot is the one being removed.
  assign tap_o = (cmd_i.rem && (idx_i == cmd_i.pos)) ? val_q : WORD_ZERO;

endmodule

>>> rtl/core/ilid_ctrl.sv
`timescale 1ns / 1ps

module ilid_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic [ilid_pkg::ACT_W-1:0]   action_i,
  input  logic [ilid_pkg::POS_W-1:0]   position_i,
  input  logic [ilid_pkg::DATA_W-1:0]  data_i,
  output ilid_pkg::cmd_t               cmd_o,
  output ilid_pkg::res_t               res_o
);
  import ilid_pkg::*;

  logic [CNT_W-1:0] count_d, count_q;
  logic [CNT_W-1:0] cnt_next;
  logic [CMP_W-1:0] pos_c, cnt_c;
  logic             ins_ok, rem_ok, is_ins, is_rem;
  status_e          status;
  action_e          act;

  always_comb begin
    act    = action_e'(action_i);
    cnt_c  = CMP_W'(count_q);
    pos_c  = '0;
    is_ins = 1'b0;
    is_rem = 1'b0;
    unique case (act)
      ACT_APPEND:    begin is_ins = 1'b1; pos_c = cnt_c;              end
      ACT_INS_FRONT: begin is_ins = 1'b1; pos_c = '0;                 end
      ACT_INS_AT:    begin is_ins = 1'b1; pos_c = CMP_W'(position_i); end
      ACT_REM_LAST:  begin is_rem = 1'b1; pos_c = cnt_c - 1'b1;       end
      ACT_REM_FIRST: begin is_rem = 1'b1; pos_c = '0;                 end
      ACT_REM_AT:    begin is_rem = 1'b1; pos_c = CMP_W'(position_i); end
      default:       begin is_ins = 1'b0; is_rem = 1'b0;              end
    endcase

    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    status   = ST_ERR;
    cnt_next = count_q;
    if (is_ins) begin
      // Position check comes before the full check.
      priority if (pos_c > cnt_c) begin
        status = ST_ERR;
      end else if (count_q == CNT_W'(CAPACITY)) begin
        status = ST_FULL;
      end else begin
        ins_ok   = 1'b1;
        status   = ST_OK;
        cnt_next = count_q + 1'b1;
      end
    end else if (is_rem && (count_q != '0) && (pos_c < cnt_c)) begin
      rem_ok   = 1'b1;
      status   = ST_OK;
      cnt_next = count_q - 1'b1;
    end

    count_d = accept_i ? cnt_next : count_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign cmd_o.ins  = accept_i && ins_ok;
  assign cmd_o.rem  = accept_i && rem_ok;
  assign cmd_o.pos  = IDX_W'(pos_c);
  assign cmd_o.data = data_i;

  assign res_o.use_sel = rem_ok;
  assign res_o.data    = ins_ok ? WORD_ZERO : WORD_ERR;
  assign res_o.status  = status;
  assign res_o.length  = LEN_W'(cnt_next);

endmodule

>>> rtl/core/indexed_list_insert_delete_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Fields                        Handshake
// in_i     in   action, position, data_in     valid/ready, taken when both high
// out_o    out  data_out, status, length      valid/ready, taken when both high
//
// One item per cycle sustained while out_o takes results; each item is decoded
// into stage 1; the second removed-value OR level feeds the output register.
// The list shifts in place: cells from the position up load new values in the
// same edge that takes the item, so the next item sees the updated list.
// Reset clears the element count and the pipeline valids; cell contents stay
// undefined until written. A stall on out_o fills the two stages, then drops
// in_i ready until the output is taken.
module indexed_list_insert_delete_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilid_in_if.sink    in_i,
  ilid_out_if.source out_o
);
  import ilid_pkg::*;

  logic accept, out_free;

  cmd_t cmd;
  res_t res;

  // Chain storage: value and removal tap of every cell, padded to full groups.
  logic [DATA_W-1:0] cell_val [CAPACITY];
  logic [DATA_W-1:0] cell_tap [NGRP*GRP];

  // Stage 1: decoded result and per-group ORs of the removal taps.
  logic              s1_valid_d, s1_valid_q;
  res_t              s1_res_q;
  logic [DATA_W-1:0] grp_d [NGRP];
  logic [DATA_W-1:0] grp_q [NGRP];

  // Output register.
  logic              out_valid_d, out_valid_q;
  logic [DATA_W-1:0] sel_val;
  logic [DATA_W-1:0] out_data_q;
  logic [ST_W-1:0]   out_status_q;
  logic [LEN_W-1:0]  out_length_q;

  // Advance the output when empty or taken; stage 1 moves whenever it can.
  assign out_free   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || out_free;
  assign accept     = in_i.valid && in_i.ready;

  ilid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .action_i   (in_i.action),
    .position_i (in_i.position),
    .data_i     (in_i.data_in),
    .cmd_o      (cmd),
    .res_o      (res)
  );

  // Row of cells. An insert pulls from the left neighbor, a removal from the
  // right one; the ends take zero, which never reaches a live slot.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left, right;

    if (i == 0) begin : g_first
      assign left = WORD_ZERO;
    end else begin : g_mid_l
      assign left = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = WORD_ZERO;
    end else begin : g_mid_r
      assign right = cell_val[i+1];
    end

    ilid_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .cmd_i   (cmd),
      .left_i  (left),
      .right_i (right),
      .val_o   (cell_val[i]),
      .tap_o   (cell_tap[i])
    );
  end

  for (genvar i = CAPACITY; i < NGRP*GRP; i++) begin : g_pad
    assign cell_tap[i] = WORD_ZERO;
  end

  // First OR level: only the removed slot drives a nonzero tap.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = WORD_ZERO;
      for (int k = 0; k < GRP; k++) begin
        grp_d[g] = grp_d[g] | cell_tap[g*GRP + k];
      end
    end
  end

  // Second OR level over the registered groups.
  always_comb begin
    sel_val = WORD_ZERO;
    for (int g = 0; g < NGRP; g++) begin
      sel_val = sel_val | grp_q[g];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (out_free) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_free ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: load on accept (stage 1) or on advance (output).
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_res_q <= res;
      grp_q    <= grp_d;
    end
    if (out_free && s1_valid_q) begin
      out_data_q   <= s1_res_q.use_sel ? sel_val : s1_res_q.data;
      out_status_q <= s1_res_q.status;
      out_length_q <= s1_res_q.length;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.data_out = out_data_q;
  assign out_o.status   = out_status_q;
  assign out_o.length   = out_length_q;

endmodule

>>> rtl/core/ilid_chk.sv
`timescale 1ns / 1ps
`include "indexed_list_insert_delete_unit_assert.svh"

module ilid_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [ilid_pkg::DATA_W-1:0]  out_data_i,
  input logic [ilid_pkg::ST_W-1:0]    out_status_i,
  input logic [ilid_pkg::LEN_W-1:0]   out_length_i
);
  import ilid_pkg::*;

  `ILID_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")
  `ILID_ASSERT(a_err_word, !out_valid_i || (out_status_i == ST_OK) || (out_data_i == WORD_ERR), "error without -1")
  `ILID_ASSERT(a_len_bound, !out_valid_i || (32'(out_length_i) <= CAPACITY), "length beyond capacity")
  `ILID_ASSERT(a_full_len, !out_valid_i || (out_status_i != ST_FULL) || (out_length_i == LEN_W'(CAPACITY)), "full status on non-full list")

endmodule

bind indexed_list_insert_delete_unit ilid_chk u_ilid_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_data_i   (out_o.data_out),
  .out_status_i (out_o.status),
  .out_length_i (out_o.length)
);
